>>> design/valve_hold_safety_controller_defines.svh
// Assertion macros shared by the valve hold safety controller RTL.
`ifndef VALVE_HOLD_SAFETY_CONTROLLER_DEFINES_SVH
`define VALVE_HOLD_SAFETY_CONTROLLER_DEFINES_SVH

// Clocked check, idle while rst_n is low.
`define VHSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define VHSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/vhsc_pkg.sv
// Types, codes and constants of the valve hold safety controller.
package vhsc_pkg;

  localparam int CHANNELS = 3;

  localparam int CNT_W     = 12;
  localparam int MIN_W     = 10;
  localparam int MODE_W    = 2;
  localparam int RUN_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [MIN_W-1:0] MIN_HOLD_RST   = 10'd250;
  localparam logic [CNT_W-1:0] MAX_HOLD_RST   = 12'd3000;
  localparam logic [CNT_W-1:0] LINK_TMO_RST   = 12'd2000;
  localparam logic [CNT_W-1:0] HOLD_RECORD_RST = 12'd250;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK      = 2'd0,
    MODE_PRESS     = 2'd1,
    MODE_RELEASE   = 2'd2,
    MODE_KEEPALIVE = 2'd3
  } mode_t;

  typedef enum logic [RUN_W-1:0] {
    RUN_READY  = 2'd0,
    RUN_FIRING = 2'd1,
    RUN_DISC   = 2'd2
  } run_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_HOLD = 2'd0,
    REG_MAX_HOLD = 2'd1,
    REG_LINK_TMO = 2'd2
  } cfg_reg_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

>>> design/vhsc_in_if.sv
// Request channel into the controller: mode and channel mask.
interface vhsc_in_if;
  import vhsc_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [CHANNELS-1:0] channel_mask;

  modport source (output valid, output mode, output channel_mask, input ready);
  modport sink   (input valid, input mode, input channel_mask, output ready);
endinterface

>>> design/vhsc_out_if.sv
// Result channel out of the controller: valve and link status.
interface vhsc_out_if;
  import vhsc_pkg::*;

  logic                valid;
  logic                ready;
  logic [CHANNELS-1:0] valve_open;
  logic [RUN_W-1:0]    run_state;
  logic                link_up;
  logic [CNT_W-1:0]    fire_time;
  logic [CNT_W-1:0]    hold_time;
  logic [CHANNELS-1:0] locked_mask;

  modport source (output valid, output valve_open, output run_state, output link_up,
                  output fire_time, output hold_time, output locked_mask,
                  input ready);
  modport sink   (input valid, input valve_open, input run_state, input link_up,
                  input fire_time, input hold_time, input locked_mask,
                  output ready);
endinterface

>>> design/valve_hold_safety_controller.sv
// Valve hold safety controller: press/release/keepalive/tick handling and status result register.
//
// Takes one request per clock and returns one status result per request, registered in the
// cycle after acceptance. All per-channel timers, the link watchdog and the hold clamp are
// updated in a single pass of logic between the request and the result register, so
// a request is taken every cycle unless the result register is full and not drained.
// A held result does not block the next request when the sink takes it the same cycle.
`include "valve_hold_safety_controller_defines.svh"

module valve_hold_safety_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  vhsc_in_if.sink                         in_ch,
  vhsc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [vhsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vhsc_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import vhsc_pkg::*;

  // configuration
  logic [MIN_W-1:0] min_hold_r;
  logic [CNT_W-1:0] max_hold_r;
  logic [CNT_W-1:0] link_tmo_r;

  // controller state
  run_state_t          run_r, run_nxt;
  logic [CHANNELS-1:0] open_r, open_nxt;
  logic [CHANNELS-1:0] lock_r, lock_nxt;
  logic [CHANNELS-1:0] pend_r, pend_nxt;
  logic [CNT_W-1:0]    since_r, since_nxt;
  logic [CNT_W-1:0]    open_time_r [CHANNELS];
  logic [CNT_W-1:0]    open_time_nxt [CHANNELS];
  logic [MIN_W-1:0]    min_left_r [CHANNELS];
  logic [MIN_W-1:0]    min_left_nxt [CHANNELS];
  logic [CNT_W-1:0]    rx_age_r, rx_age_nxt;
  logic                ever_r, ever_nxt;
  logic                link_r, link_nxt;
  logic [CNT_W-1:0]    hold_r, hold_nxt;

  // result register
  logic                out_valid_r;
  logic [CHANNELS-1:0] res_open_r;
  run_state_t          res_run_r;
  logic                res_link_r;
  logic [CNT_W-1:0]    res_elapsed_r;
  logic [CNT_W-1:0]    res_hold_r;
  logic [CHANNELS-1:0] res_lock_r;

  logic in_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    logic [CNT_W-1:0]    t;
    logic [MIN_W-1:0]    m;
    logic [CNT_W-1:0]    rx;
    logic [CNT_W-1:0]    rec;
    logic [CHANNELS-1:0] eff;
    logic                last_max;
    logic                short_hold;

    run_nxt    = run_r;
    open_nxt   = open_r;
    lock_nxt   = lock_r;
    pend_nxt   = pend_r;
    since_nxt  = since_r;
    rx_age_nxt = rx_age_r;
    ever_nxt   = ever_r;
    link_nxt   = link_r;
    hold_nxt   = hold_r;
    for (int i = 0; i < CHANNELS; i++) begin
      open_time_nxt[i] = open_time_r[i];
      min_left_nxt[i]  = min_left_r[i];
    end
    t          = '0;
    m          = '0;
    rx         = '0;
    rec        = '0;
    eff        = '0;
    last_max   = 1'b0;
    short_hold = since_r < {{(CNT_W-MIN_W){1'b0}}, min_hold_r};

    if (in_fire) begin
      if (in_ch.mode == MODE_TICK) begin
        since_nxt = sat_inc(since_r);
        // last_max ends up telling whether the highest open channel closed on max-hold
        for (int i = 0; i < CHANNELS; i++) begin
          if (open_r[i]) begin
            t                = sat_inc(open_time_r[i]);
            open_time_nxt[i] = t;
            if (t >= max_hold_r) begin
              open_nxt[i] = 1'b0;
              pend_nxt[i] = 1'b0;
              lock_nxt[i] = 1'b1;
              last_max    = 1'b1;
            end else begin
              last_max = 1'b0;
              if (pend_r[i]) begin
                m               = (min_left_r[i] != '0) ? min_left_r[i] - 1'b1 : '0;
                min_left_nxt[i] = m;
                if (m == '0) begin
                  open_nxt[i] = 1'b0;
                  pend_nxt[i] = 1'b0;
                end
              end
            end
          end
        end
        if (open_r != '0 && open_nxt == '0) begin
          run_nxt = RUN_READY;
          if (last_max) begin
            hold_nxt = max_hold_r;
          end
        end
        // link watchdog
        if (ever_r) begin
          rx         = sat_inc(rx_age_r);
          rx_age_nxt = rx;
          if (rx > link_tmo_r) begin
            if (open_nxt != '0) begin
              open_nxt = '0;
              pend_nxt = '0;
              run_nxt  = RUN_DISC;
              link_nxt = 1'b0;
            end else if (link_r) begin
              link_nxt = 1'b0;
              if (run_nxt != RUN_FIRING) begin
                run_nxt = RUN_DISC;
              end
            end
          end
        end
      end else begin
        // any non-tick request is a link receive
        rx_age_nxt = '0;
        ever_nxt   = 1'b1;
        link_nxt   = 1'b1;
        if (run_r == RUN_DISC) begin
          run_nxt = RUN_READY;
        end
        if (in_ch.mode == MODE_PRESS) begin
          eff = in_ch.channel_mask & ~open_r & ~lock_r;
          if (eff != '0) begin
            run_nxt   = RUN_FIRING;
            since_nxt = '0;
            open_nxt  = open_r | eff;
            pend_nxt  = pend_r & ~eff;
            for (int i = 0; i < CHANNELS; i++) begin
              if (eff[i]) begin
                open_time_nxt[i] = '0;
              end
            end
          end
        end else if (in_ch.mode == MODE_RELEASE) begin
          lock_nxt = '0;
          if (open_r != '0) begin
            rec = short_hold ? {{(CNT_W-MIN_W){1'b0}}, min_hold_r} : since_r;
            if (rec > max_hold_r) begin
              rec = max_hold_r;
            end
            hold_nxt = rec;
            if (short_hold) begin
              pend_nxt = pend_r | open_r;
              for (int i = 0; i < CHANNELS; i++) begin
                if (open_r[i]) begin
                  min_left_nxt[i] = min_hold_r - since_r[MIN_W-1:0];
                end
              end
            end else begin
              open_nxt = '0;
              pend_nxt = '0;
              run_nxt  = RUN_READY;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_hold_r  <= MIN_HOLD_RST;
      max_hold_r  <= MAX_HOLD_RST;
      link_tmo_r  <= LINK_TMO_RST;
      run_r       <= RUN_DISC;
      open_r      <= '0;
      lock_r      <= '0;
      pend_r      <= '0;
      since_r     <= '0;
      rx_age_r    <= '0;
      ever_r      <= 1'b0;
      link_r      <= 1'b0;
      hold_r      <= HOLD_RECORD_RST;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        open_time_r[i] <= '0;
        min_left_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_HOLD: min_hold_r <= cfg_wdata[MIN_W-1:0];
          REG_MAX_HOLD: max_hold_r <= cfg_wdata[CNT_W-1:0];
          REG_LINK_TMO: link_tmo_r <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      run_r    <= run_nxt;
      open_r   <= open_nxt;
      lock_r   <= lock_nxt;
      pend_r   <= pend_nxt;
      since_r  <= since_nxt;
      rx_age_r <= rx_age_nxt;
      ever_r   <= ever_nxt;
      link_r   <= link_nxt;
      hold_r   <= hold_nxt;
      for (int i = 0; i < CHANNELS; i++) begin
        open_time_r[i] <= open_time_nxt[i];
        min_left_r[i]  <= min_left_nxt[i];
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_open_r    <= open_nxt;
      res_run_r     <= run_nxt;
      res_link_r    <= link_nxt;
      res_elapsed_r <= (open_nxt != '0) ? since_nxt : '0;
      res_hold_r    <= hold_nxt;
      res_lock_r    <= lock_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.valve_open  = res_open_r;
  assign out_ch.run_state   = res_run_r;
  assign out_ch.link_up     = res_link_r;
  assign out_ch.fire_time   = res_elapsed_r;
  assign out_ch.hold_time   = res_hold_r;
  assign out_ch.locked_mask = res_lock_r;

  `VHSC_ASSERT(a_open_not_locked, ((open_r & lock_r) == '0), "locked channel is open")
  `VHSC_ASSERT(a_pend_in_open, ((pend_r & ~open_r) == '0), "pending bit on closed channel")
  `VHSC_ASSERT(a_firing_iff_open, ((run_r == RUN_FIRING) == (open_r != '0)), "run state disagrees with open valves")
  `VHSC_ASSERT(a_accept_gives_result, (in_fire |=> out_valid_r), "accepted request produced no result")
  `VHSC_ASSERT(a_stall_holds_result, ((out_valid_r && !out_ch.ready) |=> out_valid_r), "stalled result dropped")

endmodule
